FILE: sv/ttp_pkg.sv
// Shared types, constants and fixed-point helpers for the thermal throttle predictor.
package ttp_pkg;

  localparam int unsigned DVD_W = 60;  // dividend width of the serial divider
  localparam int unsigned DVS_W = 58;  // divisor width
  localparam int unsigned QUO_W = 18;  // quotient bits, one per cycle

  localparam int unsigned ADDR_W = 6;

  localparam logic [2:0] REG_ALPHA   = 3'd0;
  localparam logic [2:0] REG_HORIZON = 3'd1;
  localparam logic [2:0] REG_RECOV   = 3'd2;
  localparam logic [2:0] REG_RAMP    = 3'd3;
  localparam logic [2:0] REG_CKPT    = 3'd4;
  localparam logic [2:0] REG_FPS     = 3'd5;
  localparam logic [2:0] REG_RATE    = 3'd6;

  localparam logic [16:0] ALPHA_RST   = 17'd6554;
  localparam logic [31:0] HORIZON_RST = 32'd5000000;
  localparam logic [31:0] RECOV_RST   = 32'd10000000;
  localparam logic [31:0] RAMP_RST    = 32'd2000000;

  localparam logic [16:0] Q16_ONE = 17'd65536;
  localparam logic [15:0] L_ONE   = 16'd16384;
  localparam logic [15:0] L_MAX   = 16'd49152;
  localparam logic [47:0] DT_MIN  = 48'd1000;

  typedef struct packed {
    logic [16:0] alpha;
    logic [31:0] horizon;
    logic [31:0] recov;
    logic [31:0] ramp;
    logic        ckpt_en;
    logic [63:0] fps_table;
    logic [63:0] rate_table;
  } cfg_regs_t;

  typedef struct packed {
    logic fps;
    logic rate;
  } tbl_wr_t;

  function automatic logic [15:0] tbl_entry(logic [63:0] tbl, logic [1:0] idx);
    return tbl[{idx, 4'b0000} +: 16];
  endfunction

  // a + (b-a)*t/2^14 rounded to nearest, t <= 2^14
  function automatic logic [15:0] blend14(logic [15:0] a, logic [15:0] b, logic [14:0] t);
    logic [30:0] p;
    if (b >= a) begin
      p = 31'((b - a) * t) + 31'd8192;
      return a + p[29:14];
    end
    p = 31'((a - b) * t) + 31'd8192;
    return a - p[29:14];
  endfunction

  // a + (b-a)*t/2^16 rounded to nearest, t <= 2^16
  function automatic logic [15:0] blend16(logic [15:0] a, logic [15:0] b, logic [16:0] t);
    logic [33:0] p;
    if (b >= a) begin
      p = 34'((b - a) * t) + 34'd32768;
      return a + p[31:16];
    end
    p = 34'((a - b) * t) + 34'd32768;
    return a - p[31:16];
  endfunction

  function automatic logic [15:0] map_level(logic [63:0] tbl, logic [15:0] lvl);
    logic [1:0]  seg;
    logic [14:0] frac;
    seg  = lvl[15:14];
    frac = {1'b0, lvl[13:0]};
    if (seg == 2'd3) begin
      seg  = 2'd2;
      frac = 15'd16384;
    end
    return blend14(tbl_entry(tbl, seg), tbl_entry(tbl, seg + 2'd1), frac);
  endfunction

endpackage

FILE: sv/thermal_throttle_predictor.sv
// Thermal throttle predictor top level: evaluation sequencer and state.
// One evaluation (thermal level, microsecond timestamp) yields one result
// (frame rate Q8.8, training rate Q4.12, checkpoint pulse, effective level).
// Items are handled one at a time. The shared bit-serial divider computes
// the trend quotient for every item and, while a ramp is running, also the
// ramp progress; that second pass is skipped when the ramp is settled or
// disabled. A result waits in the output register while the next item is
// taken in. Writing a rate table reloads that table's target and current
// value with its nominal entry. Settings are written through the 64-bit APB
// port, one register every 8 bytes.
module thermal_throttle_predictor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_thermal_level,
  input  logic [47:0] in_time_us,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_frame_rate,
  output logic [15:0] out_training_rate,
  output logic        out_checkpoint,
  output logic [1:0]  out_effective_level,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [5:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);
  import ttp_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_EMA  = 13'b0000000000010,
    S_MAG  = 13'b0000000000100,
    S_PROD = 13'b0000000001000,
    S_DIV1 = 13'b0000000010000,
    S_PRED = 13'b0000000100000,
    S_MAPF = 13'b0000001000000,
    S_MAPR = 13'b0000010000000,
    S_PROG = 13'b0000100000000,
    S_DIV2 = 13'b0001000000000,
    S_FPS  = 13'b0010000000000,
    S_RATE = 13'b0100000000000,
    S_DONE = 13'b1000000000000
  } state_t;

  cfg_regs_t regs;
  tbl_wr_t   tbl_wr;

  ttp_cfg u_cfg (
    .clk, .rst_n, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready, .regs, .tbl_wr
  );

  logic              div_start_r, div_busy, div_done;
  logic [DVD_W-1:0]  div_dvd_r;
  logic [DVS_W-1:0]  div_dvs_r;
  logic [QUO_W-1:0]  div_quo;

  ttp_div u_div (
    .clk, .rst_n, .start(div_start_r), .dvd(div_dvd_r), .dvs(div_dvs_r),
    .busy(div_busy), .done(div_done), .quo(div_quo)
  );

  state_t      state_r;
  logic [1:0]  lvl_r;
  logic        hot_r;
  logic [47:0] now_r, dt_r, prev_time_r, serious_time_r, ramp_start_r;
  logic [15:0] ema_r, mag_r, eff_r;
  logic        neg_r, recovering_r, was_hot_r, ckpt_r;
  logic [15:0] fps_target_r, fps_now_r, rate_target_r, rate_now_r;
  logic [31:0] num_r;
  logic [57:0] den_r;
  logic [16:0] prog_r;
  logic        out_valid_r;
  logic [15:0] out_fps_r, out_rate_r;
  logic        out_ckpt_r;
  logic [1:0]  out_lvl_r;

  logic        accept, out_load;
  logic [1:0]  lvl_sat;
  logic [47:0] dt_raw;
  logic [16:0] alpha_a, inv_a;
  logic [15:0] rawq, d_abs, pred, eff_base, eff_nxt, nf, nr, fps_diff, rate_diff;
  logic [34:0] ema_sum;
  logic [15:0] ema_nxt;
  logic [59:0] dt_w, dt1800, dt1000;
  logic [32:0] mag_sum;
  logic [47:0] prod;
  logic [18:0] pos_sum;
  logic [47:0] since_serious, el;
  logic [16:0] pr;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);

  assign lvl_sat = (in_thermal_level > 3'd3) ? 2'd3 : in_thermal_level[1:0];
  assign dt_raw  = (in_time_us >= prev_time_r) ? in_time_us - prev_time_r : 48'd0;

  assign alpha_a = (regs.alpha > Q16_ONE) ? Q16_ONE : regs.alpha;
  assign inv_a   = Q16_ONE - alpha_a;
  assign rawq    = {lvl_r, 14'b0};

  assign ema_sum = {2'b0, 19'(alpha_a * lvl_r), 14'b0} + 35'(inv_a * ema_r) + 35'd32768;
  assign ema_nxt = ema_sum[31:16];

  // constant multiplies by shift and add
  assign dt_w   = {12'b0, dt_r};
  assign dt1800 = (dt_w << 11) - (dt_w << 8) + (dt_w << 3);
  assign dt1000 = (dt_w << 10) - (dt_w << 4) - (dt_w << 3);

  assign d_abs   = (rawq < ema_r) ? ema_r - rawq : rawq - ema_r;
  assign mag_sum = 33'(d_abs * alpha_a) + 33'd32768;
  assign prod    = mag_r * num_r;

  assign pos_sum = {3'b0, ema_r} + {1'b0, div_quo};
  always_comb begin
    if (neg_r) pred = ({2'b0, ema_r} <= div_quo) ? 16'd0 : ema_r - div_quo[15:0];
    else       pred = (pos_sum > {3'b0, L_MAX}) ? L_MAX : pos_sum[15:0];
  end
  assign eff_base = (rawq > pred) ? rawq : pred;
  assign since_serious = (now_r >= serious_time_r) ? now_r - serious_time_r : 48'd0;
  assign eff_nxt = hot_r ? rawq :
                   (recovering_r && since_serious < {16'b0, regs.recov} && eff_base < L_ONE)
                   ? L_ONE : eff_base;

  assign nf = map_level(regs.fps_table, eff_r);
  assign nr = map_level(regs.rate_table, eff_r);
  assign fps_diff  = (nf > fps_target_r) ? nf - fps_target_r : fps_target_r - nf;
  assign rate_diff = (nr > rate_target_r) ? nr - rate_target_r : rate_target_r - nr;

  assign el = (now_r >= ramp_start_r) ? now_r - ramp_start_r : 48'd0;
  assign pr = (prog_r > 17'd32768) ? Q16_ONE : {prog_r[15:0], 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      div_start_r    <= 1'b0;
      prev_time_r    <= '0;
      ema_r          <= '0;
      serious_time_r <= '0;
      recovering_r   <= 1'b0;
      fps_target_r   <= '0;
      fps_now_r      <= '0;
      rate_target_r  <= '0;
      rate_now_r     <= '0;
      ramp_start_r   <= '0;
      was_hot_r      <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      div_start_r <= 1'b0;
      if (out_valid_r && out_ready && !out_load) out_valid_r <= 1'b0;
      if (tbl_wr.fps) begin
        fps_target_r <= tbl_entry(cfg_pwdata, 2'd0);
        fps_now_r    <= tbl_entry(cfg_pwdata, 2'd0);
      end
      if (tbl_wr.rate) begin
        rate_target_r <= tbl_entry(cfg_pwdata, 2'd0);
        rate_now_r    <= tbl_entry(cfg_pwdata, 2'd0);
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            prev_time_r <= in_time_us;
            state_r     <= S_EMA;
          end
        end
        S_EMA: begin
          ema_r   <= ema_nxt;
          state_r <= S_MAG;
        end
        S_MAG: state_r <= S_PROD;
        S_PROD: begin
          div_start_r <= 1'b1;
          state_r     <= S_DIV1;
        end
        S_DIV1: if (div_done) state_r <= S_PRED;
        S_PRED: begin
          if (hot_r) begin
            serious_time_r <= now_r;
            recovering_r   <= 1'b1;
          end else if (recovering_r && since_serious >= {16'b0, regs.recov}) begin
            recovering_r <= 1'b0;
          end
          state_r <= S_MAPF;
        end
        S_MAPF: begin
          if (fps_diff > 16'd128) begin
            fps_target_r <= nf;
            ramp_start_r <= now_r;
          end
          state_r <= S_MAPR;
        end
        S_MAPR: begin
          if (rate_diff > 16'd40) rate_target_r <= nr;
          state_r <= S_PROG;
        end
        S_PROG: begin
          if (regs.ramp > 32'd1000 && el < {16'b0, regs.ramp}) begin
            div_start_r <= 1'b1;
            state_r     <= S_DIV2;
          end else begin
            state_r <= S_FPS;
          end
        end
        S_DIV2: if (div_done) state_r <= S_FPS;
        S_FPS: begin
          fps_now_r <= blend16(fps_now_r, fps_target_r, prog_r);
          state_r   <= S_RATE;
        end
        S_RATE: begin
          rate_now_r <= blend16(rate_now_r, rate_target_r, pr);
          was_hot_r  <= hot_r;
          state_r    <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath registers without reset
  always_ff @(posedge clk) begin
    if (accept) begin
      lvl_r <= lvl_sat;
      hot_r <= lvl_sat[1];
      now_r <= in_time_us;
      dt_r  <= (dt_raw < DT_MIN) ? DT_MIN : dt_raw;
    end
    if (state_r == S_EMA) begin
      num_r <= (dt1800 < {28'b0, regs.horizon}) ? dt1800[31:0] : regs.horizon;
      den_r <= dt1000[57:0];
    end
    if (state_r == S_MAG) begin
      neg_r <= rawq < ema_r;
      mag_r <= mag_sum[31:16];
    end
    if (state_r == S_PROD) begin
      div_dvd_r <= {12'b0, prod} + {3'b0, den_r[57:1]};
      div_dvs_r <= den_r;
    end
    if (state_r == S_PRED) eff_r <= eff_nxt;
    if (state_r == S_PROG) begin
      prog_r    <= Q16_ONE;
      div_dvd_r <= {12'b0, el[31:0], 16'b0} + {29'b0, regs.ramp[31:1]};
      div_dvs_r <= {26'b0, regs.ramp};
    end
    if (state_r == S_DIV2 && div_done)
      prog_r <= (div_quo > {1'b0, Q16_ONE}) ? Q16_ONE : div_quo[16:0];
    if (state_r == S_RATE) ckpt_r <= regs.ckpt_en && hot_r && !was_hot_r;
    if (out_load) begin
      out_fps_r  <= fps_now_r;
      out_rate_r <= rate_now_r;
      out_ckpt_r <= ckpt_r;
      out_lvl_r  <= (eff_r >= 16'd40960) ? 2'd3 :
                    (eff_r >= 16'd24576) ? 2'd2 :
                    (eff_r >= 16'd8192)  ? 2'd1 : 2'd0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_frame_rate      = out_fps_r;
  assign out_training_rate   = out_rate_r;
  assign out_checkpoint      = out_ckpt_r;
  assign out_effective_level = out_lvl_r;

  a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !div_busy)
    else $error("divider running while sequencer idle");
  a_ckpt_hot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_checkpoint) |-> (out_effective_level == 2'd2 ||
                                       out_effective_level == 2'd3))
    else $error("checkpoint below serious");
  a_recovery_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (!recovering_r || out_effective_level != 2'd0))
    else $error("recovery hold dropped below fair");
endmodule

FILE: sv/ttp_div.sv
// Restoring divider that settles one quotient bit per cycle.
module ttp_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [ttp_pkg::DVD_W-1:0]  dvd,
  input  logic [ttp_pkg::DVS_W-1:0]  dvs,
  output logic                       busy,
  output logic                       done,
  output logic [ttp_pkg::QUO_W-1:0]  quo
);
  import ttp_pkg::*;

  localparam int unsigned DSH_W = DVS_W + QUO_W - 1;
  localparam int unsigned CNT_W = $clog2(QUO_W + 1);

  logic             busy_r, done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVD_W-1:0] rem_r;
  logic [DSH_W-1:0] dsh_r;
  logic [QUO_W-1:0] quo_r;
  logic             ge;

  assign ge = {{(DSH_W - DVD_W){1'b0}}, rem_r} >= dsh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(QUO_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dvd;
      dsh_r <= {dvs, {(QUO_W - 1){1'b0}}};
      quo_r <= '0;
    end else if (busy_r) begin
      if (ge) rem_r <= rem_r - dsh_r[DVD_W-1:0];
      quo_r <= {quo_r[QUO_W-2:0], ge};
      dsh_r <= dsh_r >> 1;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = quo_r;

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n) start |-> !busy_r)
    else $error("divider started while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider done without a run");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n) done_r |=> !done_r)
    else $error("divider done held");
endmodule

FILE: sv/ttp_cfg.sv
// APB register file for the predictor settings and rate tables.
module ttp_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [ttp_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [63:0]                 cfg_pwdata,
  output logic [63:0]                 cfg_prdata,
  output logic                        cfg_pready,
  output ttp_pkg::cfg_regs_t          regs,
  output ttp_pkg::tbl_wr_t            tbl_wr
);
  import ttp_pkg::*;

  cfg_regs_t  regs_r;
  logic       wr_en;
  logic [2:0] idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign idx        = cfg_paddr[5:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.alpha      <= ALPHA_RST;
      regs_r.horizon    <= HORIZON_RST;
      regs_r.recov      <= RECOV_RST;
      regs_r.ramp       <= RAMP_RST;
      regs_r.ckpt_en    <= 1'b1;
      regs_r.fps_table  <= '0;
      regs_r.rate_table <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_ALPHA:   regs_r.alpha      <= cfg_pwdata[16:0];
        REG_HORIZON: regs_r.horizon    <= cfg_pwdata[31:0];
        REG_RECOV:   regs_r.recov      <= cfg_pwdata[31:0];
        REG_RAMP:    regs_r.ramp       <= cfg_pwdata[31:0];
        REG_CKPT:    regs_r.ckpt_en    <= cfg_pwdata[0];
        REG_FPS:     regs_r.fps_table  <= cfg_pwdata;
        REG_RATE:    regs_r.rate_table <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ALPHA:   cfg_prdata = {47'b0, regs_r.alpha};
      REG_HORIZON: cfg_prdata = {32'b0, regs_r.horizon};
      REG_RECOV:   cfg_prdata = {32'b0, regs_r.recov};
      REG_RAMP:    cfg_prdata = {32'b0, regs_r.ramp};
      REG_CKPT:    cfg_prdata = {63'b0, regs_r.ckpt_en};
      REG_FPS:     cfg_prdata = regs_r.fps_table;
      REG_RATE:    cfg_prdata = regs_r.rate_table;
      default:     cfg_prdata = '0;
    endcase
  end

  assign regs        = regs_r;
  assign tbl_wr.fps  = wr_en && (idx == REG_FPS);
  assign tbl_wr.rate = wr_en && (idx == REG_RATE);
endmodule
